>>> src/mpoly_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpoly_pkg
// Shared constants, types and helpers of the multivariate polynomial
// evaluator: command and status codes, exponent packing, saturating add.
// ----------------------------------------------------------------------------
package mpoly_pkg;

   localparam int NUM_VARS  = 4;
   localparam int MAX_TERMS = 64;
   localparam int POWER_CAP = 4;

   localparam int POW_W   = 3;
   localparam int EXP_W   = 12;
   localparam int COEF_W  = 32;
   localparam int X_W     = 24;
   localparam int RES_W   = 48;
   localparam int FRAC_W  = 20;
   localparam int IDX_W   = 6;
   localparam int CNT_W   = 7;
   localparam int ENTRY_W = EXP_W + COEF_W;

   localparam logic [2:0] CMD_CLEAR  = 3'd0;
   localparam logic [2:0] CMD_APPEND = 3'd1;
   localparam logic [2:0] CMD_EVAL   = 3'd2;
   localparam logic [2:0] CMD_TERMS  = 3'd3;
   localparam logic [2:0] CMD_READ   = 3'd4;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_FULL  = 3'd1;
   localparam logic [2:0] ST_RANGE = 3'd2;
   localparam logic [2:0] ST_EMPTY = 3'd3;
   localparam logic [2:0] ST_SAT   = 3'd4;

   localparam logic signed [RES_W-1:0] ONE_Q20 = 48'sd1 <<< FRAC_W;
   localparam logic signed [RES_W-1:0] POS_LIM = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [RES_W-1:0] NEG_LIM = 48'sh8000_0000_0000;

   typedef struct packed {
      logic                     start;
      logic signed [RES_W-1:0]  a;
      logic signed [COEF_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                    done;
      logic                    sat;
      logic signed [RES_W-1:0] p;
   } mul_rsp_type;

   function automatic logic [POW_W-1:0] expo(input logic [EXP_W-1:0] pw,
                                              input logic [1:0] d);
      return pw[POW_W*d +: POW_W];
   endfunction

   function automatic logic [POW_W-1:0] clamp_pow(input logic [POW_W-1:0] p);
      return (p > POW_W'(POWER_CAP)) ? POW_W'(POWER_CAP) : p;
   endfunction

   // bit RES_W flags saturation
   function automatic logic [RES_W:0] sat_add(input logic signed [RES_W-1:0] a,
                                              input logic signed [RES_W-1:0] b);
      logic signed [RES_W:0] s;
      s = {a[RES_W-1], a} + {b[RES_W-1], b};
      if (s > $signed({POS_LIM[RES_W-1], POS_LIM}))
         return {1'b1, POS_LIM};
      else if (s < $signed({NEG_LIM[RES_W-1], NEG_LIM}))
         return {1'b1, NEG_LIM};
      else
         return {1'b0, s[RES_W-1:0]};
   endfunction

endpackage
`default_nettype wire

>>> src/mpoly_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpoly_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mpoly_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]         wr_data,
   input  wire  [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en)
         mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

>>> src/mpoly_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpoly_mul
// Multi-cycle Q.20 multiplier: 48 x 32 bit signed via two 24 x 32 partial
// products, round half away from zero, saturate to 48 bits.
// ----------------------------------------------------------------------------
module mpoly_mul (
   input  wire                        clock,
   input  wire                        reset,
   input  wire mpoly_pkg::mul_req_type req,
   output mpoly_pkg::mul_rsp_type     rsp
);

   localparam logic [2:0] M_IDLE = 3'd0;
   localparam logic [2:0] M_LO   = 3'd1;
   localparam logic [2:0] M_HI   = 3'd2;
   localparam logic [2:0] M_RND  = 3'd3;
   localparam logic [2:0] M_SAT  = 3'd4;

   logic [2:0]  ph_ff, ph_in;
   logic [47:0] am_ff;
   logic [31:0] bm_ff;
   logic        neg_ff;
   logic [55:0] plo_ff, phi_ff;
   logic [59:0] rnd_ff;
   logic        done_ff, done_in;
   logic        sat_ff;
   logic [47:0] res_ff;
   logic [79:0] sum;
   logic [59:0] lim;
   logic [59:0] mag;
   logic        ovf;

   assign sum = {phi_ff, 24'd0} + {24'd0, plo_ff} + 80'd524288;
   assign lim = neg_ff ? 60'h8000_0000_0000 : 60'h7FFF_FFFF_FFFF;
   assign ovf = rnd_ff > lim;
   assign mag = ovf ? lim : rnd_ff;

   always_comb begin
      ph_in   = ph_ff;
      done_in = 1'b0;
      unique case (ph_ff)
         M_IDLE: if (req.start) ph_in = M_LO;
         M_LO:   ph_in = M_HI;
         M_HI:   ph_in = M_RND;
         M_RND:  ph_in = M_SAT;
         M_SAT: begin
            ph_in   = M_IDLE;
            done_in = 1'b1;
         end
         default: ph_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff   <= M_IDLE;
         done_ff <= 1'b0;
      end else begin
         ph_ff   <= ph_in;
         done_ff <= done_in;
      end
      if (ph_ff == M_IDLE && req.start) begin
         am_ff  <= req.a[47] ? 48'(-req.a) : 48'(req.a);
         bm_ff  <= req.b[31] ? 32'(-req.b) : 32'(req.b);
         neg_ff <= req.a[47] ^ req.b[31];
      end
      if (ph_ff == M_LO)
         plo_ff <= am_ff[23:0] * bm_ff;
      if (ph_ff == M_HI)
         phi_ff <= am_ff[47:24] * bm_ff;
      if (ph_ff == M_RND)
         rnd_ff <= sum[79:20];
      if (ph_ff == M_SAT) begin
         res_ff <= neg_ff ? 48'(-mag[47:0]) : mag[47:0];
         sat_ff <= ovf;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.sat  = sat_ff;
   assign rsp.p    = res_ff;

endmodule
`default_nettype wire

>>> src/multivariate_poly_eval_gradient_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multivariate_poly_eval_gradient_top
// Term table in one RAM; a sequencer walks the terms and drives a shared
// multi-cycle multiplier for monomials, gradients and coefficient products.
// Clear, append, empty evaluate and out-of-range read answer from the dispatch
// state; a read in range first waits for the registered RAM read data.
// Per term the chain multiplies once per unit of power; value and gradient mode
// adds coefficient multiplies and a gradient pass per variable with p_g > 0.
// One item at a time; input stalls until the last result is registered.
// Reset (synchronous) empties the table by zeroing the count; RAM is not cleared.
// ----------------------------------------------------------------------------
module multivariate_poly_eval_gradient_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [2:0]  req_command,
   input  wire  [5:0]  req_elem_index,
   input  wire  signed [23:0] req_x0,
   input  wire  signed [23:0] req_x1,
   input  wire  signed [23:0] req_x2,
   input  wire  signed [23:0] req_x3,
   input  wire  [2:0]  req_pow0,
   input  wire  [2:0]  req_pow1,
   input  wire  [2:0]  req_pow2,
   input  wire  [2:0]  req_pow3,
   input  wire  signed [31:0] req_coefficient,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic signed [47:0] rsp_value,
   output logic signed [47:0] rsp_grad_0,
   output logic signed [47:0] rsp_grad_1,
   output logic signed [47:0] rsp_grad_2,
   output logic signed [47:0] rsp_grad_3,
   output logic [5:0]  rsp_term_index,
   output logic [11:0] rsp_powers_packed,
   output logic        rsp_last,
   output logic [2:0]  rsp_status
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DISP  = 4'd1;
   localparam logic [3:0] S_RDD   = 4'd2;
   localparam logic [3:0] S_TLOAD = 4'd3;
   localparam logic [3:0] S_TDATA = 4'd4;
   localparam logic [3:0] S_PINIT = 4'd5;
   localparam logic [3:0] S_CHAIN = 4'd6;
   localparam logic [3:0] S_MWAIT = 4'd7;
   localparam logic [3:0] S_ACC   = 4'd8;
   localparam logic [3:0] S_TEMIT = 4'd9;
   localparam logic [3:0] S_VEMIT = 4'd10;

   logic [3:0]  state_ff, state_in;
   logic [2:0]  cmd_ff;
   logic [5:0]  idx_ff;
   logic signed [23:0] x_ff [mpoly_pkg::NUM_VARS];
   logic [11:0] pwin_ff;
   logic [31:0] coefin_ff;
   logic [6:0]  count_ff, count_in;
   logic [5:0]  term_ff, term_in;
   logic [11:0] pw_ff, pw_in;
   logic signed [31:0] coef_ff, coef_in;
   logic [2:0]  pass_ff, pass_in;
   logic [1:0]  d_ff, d_in;
   logic [2:0]  k_ff, k_in;
   logic        ret_ff, ret_in;
   logic signed [47:0] acc_ff, acc_in;
   logic        sat_ff, sat_in;
   logic signed [47:0] val_ff, val_in;
   logic signed [47:0] grad_ff [mpoly_pkg::NUM_VARS];
   logic signed [47:0] grad_in [mpoly_pkg::NUM_VARS];

   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [47:0] rsp_value_ff, rsp_value_in;
   logic signed [47:0] rsp_grad_ff [mpoly_pkg::NUM_VARS];
   logic signed [47:0] rsp_grad_in [mpoly_pkg::NUM_VARS];
   logic [5:0]  rsp_ti_ff, rsp_ti_in;
   logic [11:0] rsp_pw_ff, rsp_pw_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;

   logic        req_take, out_free, last_term;
   logic [11:0] pw_clamped;
   logic        wr_en;
   logic [5:0]  rd_addr;
   logic [43:0] rd_data;
   logic [2:0]  p_cur, p_lim;
   logic [1:0]  gvar;
   logic [48:0] add_res;
   logic signed [47:0] add_src;
   mpoly_pkg::mul_req_type mul_req;
   mpoly_pkg::mul_rsp_type mul_rsp;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = state_ff != S_IDLE;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_term = ({1'b0, term_ff} + 7'd1) == count_ff;
   assign gvar      = pass_ff[1:0] - 2'd1;
   assign p_cur     = mpoly_pkg::expo(pw_ff, d_ff);
   assign p_lim     = (pass_ff != 3'd0 && d_ff == gvar) ? p_cur - 3'd1 : p_cur;
   assign add_src   = (pass_ff == 3'd0) ? val_ff : grad_ff[gvar];
   assign add_res   = mpoly_pkg::sat_add(add_src, acc_ff);
   assign rd_addr   = (cmd_ff == mpoly_pkg::CMD_READ) ? idx_ff : term_ff;
   assign wr_en     = state_ff == S_DISP && cmd_ff == mpoly_pkg::CMD_APPEND && out_free
                      && count_ff < 7'(mpoly_pkg::MAX_TERMS);

   always_comb begin
      pw_clamped = {mpoly_pkg::clamp_pow(req_pow3), mpoly_pkg::clamp_pow(req_pow2),
                    mpoly_pkg::clamp_pow(req_pow1), mpoly_pkg::clamp_pow(req_pow0)};
   end

   mpoly_ram #(
      .WIDTH (mpoly_pkg::ENTRY_W),
      .DEPTH (mpoly_pkg::MAX_TERMS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[5:0]),
      .wr_data ({pwin_ff, coefin_ff}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mpoly_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      term_in       = term_ff;
      pw_in         = pw_ff;
      coef_in       = coef_ff;
      pass_in       = pass_ff;
      d_in          = d_ff;
      k_in          = k_ff;
      ret_in        = ret_ff;
      acc_in        = acc_ff;
      sat_in        = sat_ff;
      val_in        = val_ff;
      grad_in       = grad_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_grad_in   = rsp_grad_ff;
      rsp_ti_in     = rsp_ti_ff;
      rsp_pw_in     = rsp_pw_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      mul_req.start = 1'b0;
      mul_req.a     = acc_ff;
      mul_req.b     = 32'(signed'(x_ff[d_ff]));

      unique case (state_ff)
         S_IDLE: begin
            if (req_take)
               state_in = S_DISP;
         end
         S_DISP: begin
            unique case (cmd_ff) inside
               mpoly_pkg::CMD_CLEAR, mpoly_pkg::CMD_APPEND: begin
                  if (out_free) begin
                     rsp_valid_in  = 1'b1;
                     rsp_value_in  = '0;
                     rsp_grad_in   = '{default: '0};
                     rsp_pw_in     = '0;
                     rsp_last_in   = 1'b1;
                     rsp_ti_in     = '0;
                     rsp_status_in = mpoly_pkg::ST_OK;
                     state_in      = S_IDLE;
                     if (cmd_ff == mpoly_pkg::CMD_CLEAR) begin
                        count_in = '0;
                     end else if (count_ff >= 7'(mpoly_pkg::MAX_TERMS)) begin
                        rsp_status_in = mpoly_pkg::ST_FULL;
                     end else begin
                        rsp_ti_in = count_ff[5:0];
                        count_in  = count_ff + 7'd1;
                     end
                  end
               end
               mpoly_pkg::CMD_READ: begin
                  if ({1'b0, idx_ff} < count_ff) begin
                     state_in = S_RDD;
                  end else if (out_free) begin
                     rsp_valid_in  = 1'b1;
                     rsp_value_in  = '0;
                     rsp_grad_in   = '{default: '0};
                     rsp_pw_in     = '0;
                     rsp_last_in   = 1'b1;
                     rsp_ti_in     = idx_ff;
                     rsp_status_in = mpoly_pkg::ST_RANGE;
                     state_in      = S_IDLE;
                  end
               end
               mpoly_pkg::CMD_EVAL, mpoly_pkg::CMD_TERMS: begin
                  if (count_ff != '0) begin
                     term_in  = '0;
                     val_in   = '0;
                     grad_in  = '{default: '0};
                     sat_in   = 1'b0;
                     state_in = S_TLOAD;
                  end else if (out_free) begin
                     rsp_valid_in  = 1'b1;
                     rsp_value_in  = '0;
                     rsp_grad_in   = '{default: '0};
                     rsp_pw_in     = '0;
                     rsp_last_in   = 1'b1;
                     rsp_ti_in     = '0;
                     rsp_status_in = mpoly_pkg::ST_EMPTY;
                     state_in      = S_IDLE;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_RDD: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = 48'(signed'(rd_data[31:0]));
               rsp_grad_in   = '{default: '0};
               rsp_pw_in     = rd_data[43:32];
               rsp_last_in   = 1'b1;
               rsp_ti_in     = idx_ff;
               rsp_status_in = mpoly_pkg::ST_OK;
               state_in      = S_IDLE;
            end
         end
         S_TLOAD: state_in = S_TDATA;
         S_TDATA: begin
            pw_in    = rd_data[43:32];
            coef_in  = rd_data[31:0];
            pass_in  = '0;
            if (cmd_ff == mpoly_pkg::CMD_TERMS)
               sat_in = 1'b0;
            state_in = S_PINIT;
         end
         S_PINIT: begin
            d_in = '0;
            k_in = '0;
            if (pass_ff == 3'd0) begin
               acc_in   = mpoly_pkg::ONE_Q20;
               state_in = S_CHAIN;
            end else if (mpoly_pkg::expo(pw_ff, gvar) != '0) begin
               acc_in   = 48'(mpoly_pkg::expo(pw_ff, gvar)) <<< mpoly_pkg::FRAC_W;
               state_in = S_CHAIN;
            end else if (pass_ff == 3'(mpoly_pkg::NUM_VARS)) begin
               if (last_term) begin
                  state_in = S_VEMIT;
               end else begin
                  term_in  = term_ff + 6'd1;
                  state_in = S_TLOAD;
               end
            end else begin
               pass_in = pass_ff + 3'd1;
            end
         end
         S_CHAIN: begin
            if (k_ff < p_lim) begin
               mul_req.start = 1'b1;
               k_in          = k_ff + 3'd1;
               ret_in        = 1'b0;
               state_in      = S_MWAIT;
            end else if (d_ff == 2'(mpoly_pkg::NUM_VARS - 1)) begin
               if (cmd_ff == mpoly_pkg::CMD_TERMS) begin
                  state_in = S_TEMIT;
               end else begin
                  mul_req.start = 1'b1;
                  mul_req.b     = coef_ff;
                  ret_in        = 1'b1;
                  state_in      = S_MWAIT;
               end
            end else begin
               d_in = d_ff + 2'd1;
               k_in = '0;
            end
         end
         S_MWAIT: begin
            if (mul_rsp.done) begin
               acc_in   = mul_rsp.p;
               sat_in   = sat_ff | mul_rsp.sat;
               state_in = ret_ff ? S_ACC : S_CHAIN;
            end
         end
         S_ACC: begin
            sat_in = sat_ff | add_res[48];
            if (pass_ff == 3'd0)
               val_in = add_res[47:0];
            else
               grad_in[gvar] = add_res[47:0];
            if (pass_ff == 3'(mpoly_pkg::NUM_VARS)) begin
               if (last_term) begin
                  state_in = S_VEMIT;
               end else begin
                  term_in  = term_ff + 6'd1;
                  state_in = S_TLOAD;
               end
            end else begin
               pass_in  = pass_ff + 3'd1;
               state_in = S_PINIT;
            end
         end
         S_TEMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = acc_ff;
               rsp_grad_in   = '{default: '0};
               rsp_pw_in     = pw_ff;
               rsp_last_in   = last_term;
               rsp_ti_in     = term_ff;
               rsp_status_in = sat_ff ? mpoly_pkg::ST_SAT : mpoly_pkg::ST_OK;
               if (last_term) begin
                  state_in = S_IDLE;
               end else begin
                  term_in  = term_ff + 6'd1;
                  state_in = S_TLOAD;
               end
            end
         end
         S_VEMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = val_ff;
               rsp_grad_in   = grad_ff;
               rsp_pw_in     = '0;
               rsp_last_in   = 1'b1;
               rsp_ti_in     = '0;
               rsp_status_in = sat_ff ? mpoly_pkg::ST_SAT : mpoly_pkg::ST_OK;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take) begin
         cmd_ff    <= req_command;
         idx_ff    <= req_elem_index;
         x_ff[0]   <= req_x0;
         x_ff[1]   <= req_x1;
         x_ff[2]   <= req_x2;
         x_ff[3]   <= req_x3;
         pwin_ff   <= pw_clamped;
         coefin_ff <= req_coefficient;
      end
      term_ff       <= term_in;
      pw_ff         <= pw_in;
      coef_ff       <= coef_in;
      pass_ff       <= pass_in;
      d_ff          <= d_in;
      k_ff          <= k_in;
      ret_ff        <= ret_in;
      acc_ff        <= acc_in;
      sat_ff        <= sat_in;
      val_ff        <= val_in;
      grad_ff       <= grad_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_grad_ff   <= rsp_grad_in;
      rsp_ti_ff     <= rsp_ti_in;
      rsp_pw_ff     <= rsp_pw_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_value         = rsp_value_ff;
   assign rsp_grad_0        = rsp_grad_ff[0];
   assign rsp_grad_1        = rsp_grad_ff[1];
   assign rsp_grad_2        = rsp_grad_ff[2];
   assign rsp_grad_3        = rsp_grad_ff[3];
   assign rsp_term_index    = rsp_ti_ff;
   assign rsp_powers_packed = rsp_pw_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_status        = rsp_status_ff;

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 7'(mpoly_pkg::MAX_TERMS))
      else $error("term count above table depth");

   a_mul_done_wait: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> state_ff == S_MWAIT)
      else $error("multiplier finished outside wait state");

   a_accept_disp: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == S_DISP)
      else $error("accepted item not dispatched");

   a_nonlast_terms: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> cmd_ff == mpoly_pkg::CMD_TERMS)
      else $error("non-final item outside per-term run");

endmodule
`default_nettype wire

>>> tb/multivariate_poly_eval_gradient_checker.sv
// ----------------------------------------------------------------------------
// multivariate_poly_eval_gradient_checker
// Watches the request and response channels of the polynomial evaluator,
// keeps its own term table, predicts the responses of each accepted request
// in fixed point and compares every accepted response field by field.
// ----------------------------------------------------------------------------
module multivariate_poly_eval_gradient_checker
   import mpoly_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [2:0]         req_command,
   input  logic [5:0]         req_elem_index,
   input  logic signed [23:0] req_x0,
   input  logic signed [23:0] req_x1,
   input  logic signed [23:0] req_x2,
   input  logic signed [23:0] req_x3,
   input  logic [2:0]         req_pow0,
   input  logic [2:0]         req_pow1,
   input  logic [2:0]         req_pow2,
   input  logic [2:0]         req_pow3,
   input  logic signed [31:0] req_coefficient,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [47:0] rsp_value,
   input  logic signed [47:0] rsp_grad_0,
   input  logic signed [47:0] rsp_grad_1,
   input  logic signed [47:0] rsp_grad_2,
   input  logic signed [47:0] rsp_grad_3,
   input  logic [5:0]         rsp_term_index,
   input  logic [11:0]        rsp_powers_packed,
   input  logic               rsp_last,
   input  logic [2:0]         rsp_status,
   output int                 fail_count,
   output int                 pending
);

   typedef struct {
      logic [47:0] value;
      logic [47:0] grad [4];
      logic [5:0]  term_index;
      logic [11:0] powers;
      logic        last;
      logic [2:0]  status;
   } poly_rsp_type;

   localparam logic signed [63:0] Q_POS = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] Q_NEG = -64'sh0000_8000_0000_0000;

   poly_rsp_type       rsp_q [$];
   int                 term_cnt;
   logic [11:0]        exp_tab  [MAX_TERMS];
   logic signed [31:0] coef_tab [MAX_TERMS];
   bit                 run_sat;

   function automatic logic signed [63:0] q_mul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
      bit           neg;
      logic [127:0] ua, ub, p, r, lim;
      neg = (a < 0) != (b < 0);
      ua  = (a < 0) ? 128'(-a) : 128'(a);
      ub  = (b < 0) ? 128'(-b) : 128'(b);
      p   = ua * ub;
      r   = (p + (128'd1 << 19)) >> 20;
      lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
      if (r > lim) begin
         r = lim;
         run_sat = 1;
      end
      return neg ? -$signed(r[63:0]) : $signed(r[63:0]);
   endfunction

   function automatic logic signed [63:0] q_add(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (s > Q_POS) begin
         run_sat = 1;
         return Q_POS;
      end
      if (s < Q_NEG) begin
         run_sat = 1;
         return Q_NEG;
      end
      return s;
   endfunction

   function automatic logic signed [63:0] power_chain(input logic signed [63:0] acc,
                                                      input logic signed [63:0] xv [4],
                                                      input logic [11:0] pw,
                                                      input int skip);
      int p;
      for (int d = 0; d < NUM_VARS; d++) begin
         p = int'(pw[3*d +: 3]);
         if (d == skip) p = p - 1;
         for (int k = 0; k < p; k++) acc = q_mul(acc, xv[d]);
      end
      return acc;
   endfunction

   function automatic poly_rsp_type blank_rsp();
      poly_rsp_type r;
      r.value = 0;
      for (int g = 0; g < 4; g++) r.grad[g] = 0;
      r.term_index = 0;
      r.powers = 0;
      r.last = 1;
      r.status = ST_OK;
      return r;
   endfunction

   task automatic predict_request();
      poly_rsp_type       r;
      logic signed [63:0] xv [4];
      logic signed [63:0] val, m, c, t;
      logic signed [63:0] grad [4];
      logic [11:0]        pw;
      logic [2:0]         p;
      logic [2:0]         pin [4];
      xv[0] = 64'(req_x0); xv[1] = 64'(req_x1); xv[2] = 64'(req_x2); xv[3] = 64'(req_x3);
      pin[0] = req_pow0; pin[1] = req_pow1; pin[2] = req_pow2; pin[3] = req_pow3;
      r = blank_rsp();
      case (req_command) inside
         CMD_CLEAR: begin
            term_cnt = 0;
            rsp_q.insert(rsp_q.size(), r);
         end
         CMD_APPEND: begin
            if (term_cnt >= MAX_TERMS) begin
               r.status = ST_FULL;
            end else begin
               pw = 0;
               for (int d = 0; d < NUM_VARS; d++) begin
                  p = (pin[d] > POWER_CAP) ? 3'(POWER_CAP) : pin[d];
                  pw[3*d +: 3] = p;
               end
               exp_tab[term_cnt]  = pw;
               coef_tab[term_cnt] = req_coefficient;
               r.term_index = 6'(term_cnt);
               term_cnt++;
            end
            rsp_q.insert(rsp_q.size(), r);
         end
         CMD_READ: begin
            r.term_index = req_elem_index;
            if (req_elem_index >= term_cnt) begin
               r.status = ST_RANGE;
            end else begin
               r.value  = 48'(coef_tab[req_elem_index]);
               r.powers = exp_tab[req_elem_index];
            end
            rsp_q.insert(rsp_q.size(), r);
         end
         CMD_EVAL, CMD_TERMS: begin
            if (term_cnt == 0) begin
               r.status = ST_EMPTY;
               rsp_q.insert(rsp_q.size(), r);
            end else if (req_command == CMD_TERMS) begin
               for (int i = 0; i < term_cnt; i++) begin
                  run_sat = 0;
                  m = power_chain(64'sd1 <<< 20, xv, exp_tab[i], -1);
                  r = blank_rsp();
                  r.value = m[47:0];
                  r.term_index = 6'(i);
                  r.powers = exp_tab[i];
                  r.last = (i + 1 == term_cnt);
                  r.status = run_sat ? ST_SAT : ST_OK;
                  rsp_q.insert(rsp_q.size(), r);
               end
            end else begin
               run_sat = 0;
               val = 0;
               for (int g = 0; g < 4; g++) grad[g] = 0;
               for (int i = 0; i < term_cnt; i++) begin
                  pw = exp_tab[i];
                  c  = 64'(coef_tab[i]);
                  m  = power_chain(64'sd1 <<< 20, xv, pw, -1);
                  val = q_add(val, q_mul(m, c));
                  for (int g = 0; g < NUM_VARS; g++) begin
                     if (pw[3*g +: 3] != 0) begin
                        t = power_chain(64'(pw[3*g +: 3]) <<< 20, xv, pw, g);
                        grad[g] = q_add(grad[g], q_mul(t, c));
                     end
                  end
               end
               r.value = val[47:0];
               for (int g = 0; g < 4; g++) r.grad[g] = grad[g][47:0];
               r.status = run_sat ? ST_SAT : ST_OK;
               rsp_q.insert(rsp_q.size(), r);
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [47:0] exp_v,
                              input logic [47:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %h, actual %h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   task automatic compare_response();
      poly_rsp_type e;
      if (rsp_q.size() == 0) begin
         $error("unexpected response item: value %h status %0d", rsp_value, rsp_status);
         fail_count++;
         return;
      end
      e = rsp_q.pop_front();
      check_field("value", e.value, rsp_value);
      check_field("grad_0", e.grad[0], rsp_grad_0);
      check_field("grad_1", e.grad[1], rsp_grad_1);
      check_field("grad_2", e.grad[2], rsp_grad_2);
      check_field("grad_3", e.grad[3], rsp_grad_3);
      check_field("term_index", 48'(e.term_index), 48'(rsp_term_index));
      check_field("powers_packed", 48'(e.powers), 48'(rsp_powers_packed));
      check_field("last", 48'(e.last), 48'(rsp_last));
      check_field("status", 48'(e.status), 48'(rsp_status));
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
      term_cnt = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         term_cnt = 0;
         rsp_q.delete();
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) compare_response();
         if (req_valid === 1'b1 && req_stall === 1'b0) predict_request();
      end
      pending = rsp_q.size();
   end

endmodule

>>> tb/multivariate_poly_eval_gradient_top_tb.sv
// ----------------------------------------------------------------------------
// multivariate_poly_eval_gradient_top_tb
// Drives the polynomial evaluator with a directed set of commands and then
// random table builds, evaluations and reads under random idling on both
// channels; a checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module multivariate_poly_eval_gradient_top_tb;
   import mpoly_pkg::*;

   localparam int IDLE_LIMIT = 400000;
   localparam logic [2:0] CMD_NONE5 = 3'd5;
   localparam logic [2:0] CMD_NONE6 = 3'd6;
   localparam logic [2:0] CMD_NONE7 = 3'd7;

   typedef struct {
      logic [2:0]         command;
      logic [5:0]         index;
      logic signed [23:0] x [4];
      logic [2:0]         pw [4];
      logic signed [31:0] coef;
   } poly_cmd_type;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic [2:0]         req_command = 0;
   logic [5:0]         req_elem_index = 0;
   logic signed [23:0] req_x0 = 0, req_x1 = 0, req_x2 = 0, req_x3 = 0;
   logic [2:0]         req_pow0 = 0, req_pow1 = 0, req_pow2 = 0, req_pow3 = 0;
   logic signed [31:0] req_coefficient = 0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic signed [47:0] rsp_value, rsp_grad_0, rsp_grad_1, rsp_grad_2, rsp_grad_3;
   logic [5:0]         rsp_term_index;
   logic [11:0]        rsp_powers_packed;
   logic               rsp_last;
   logic [2:0]         rsp_status;
   int                 fail_count;
   int                 pending;
   bit                 quiet = 0;
   bit                 random_phase = 0;
   int                 idle_cycles = 0;

   multivariate_poly_eval_gradient_top u_top (.*);

   multivariate_poly_eval_gradient_checker u_checker (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("multivariate_poly_eval_gradient_top_tb failed");
         $finish;
      end
   end

   initial begin
      int n;
      bit long_done;
      long_done = 0;
      @(posedge clock);
      forever begin
         if (quiet) begin
            rsp_stall <= 0;
            @(posedge clock);
         end else if (random_phase && !long_done) begin
            rsp_stall <= 1;
            repeat (600) @(posedge clock);
            long_done = 1;
         end else begin
            n = $urandom_range(1, 12);
            rsp_stall <= ($urandom_range(0, 2) == 0);
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic send(input poly_cmd_type c);
      req_valid       <= 1;
      req_command     <= c.command;
      req_elem_index  <= c.index;
      req_x0 <= c.x[0]; req_x1 <= c.x[1]; req_x2 <= c.x[2]; req_x3 <= c.x[3];
      req_pow0 <= c.pw[0]; req_pow1 <= c.pw[1]; req_pow2 <= c.pw[2];
      req_pow3 <= c.pw[3];
      req_coefficient <= c.coef;
      do @(posedge clock); while (req_stall);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   function automatic poly_cmd_type make_cmd(input logic [2:0] cmd);
      poly_cmd_type c;
      c.command = cmd;
      c.index = 6'($urandom);
      for (int d = 0; d < 4; d++) begin
         c.x[d] = 24'($urandom);
         c.pw[d] = 3'($urandom);
      end
      c.coef = $urandom;
      return c;
   endfunction

   function automatic logic signed [23:0] rand_x();
      case ($urandom_range(0, 3))
         0: return 24'($urandom);
         1: return 24'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
         2: return ($urandom_range(0, 1)) ? 24'sh100000 : -24'sh100000;
         default: return 24'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      endcase
   endfunction

   function automatic poly_cmd_type make_eval(input logic [2:0] cmd);
      poly_cmd_type c;
      c = make_cmd(cmd);
      for (int d = 0; d < 4; d++) c.x[d] = rand_x();
      return c;
   endfunction

   function automatic poly_cmd_type make_term(input logic [2:0] max_p);
      poly_cmd_type c;
      c = make_cmd(CMD_APPEND);
      for (int d = 0; d < 4; d++) c.pw[d] = 3'($urandom_range(0, max_p));
      if ($urandom_range(0, 1)) c.coef = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
      return c;
   endfunction

   function automatic poly_cmd_type with_x(input logic [2:0] cmd, input logic signed [23:0] v);
      poly_cmd_type c;
      c = make_cmd(cmd);
      for (int d = 0; d < 4; d++) c.x[d] = v;
      return c;
   endfunction

   initial begin
      poly_cmd_type c;
      int items;
      int terms;
      int target;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send(make_cmd(CMD_NONE5));
      send(make_eval(CMD_EVAL));
      send(make_eval(CMD_TERMS));
      c = make_cmd(CMD_READ); c.index = 0; send(c);
      c = make_cmd(CMD_APPEND);
      for (int d = 0; d < 4; d++) c.pw[d] = 3'd7;
      c.coef = 32'sh7FFF_FFFF; send(c);
      c = make_cmd(CMD_APPEND);
      for (int d = 0; d < 4; d++) c.pw[d] = 3'd0;
      c.coef = 32'sh8000_0000; send(c);
      c = make_cmd(CMD_APPEND);
      for (int d = 0; d < 4; d++) c.pw[d] = 3'(d + 1);
      c.coef = 32'sh0010_0000; send(c);
      send(with_x(CMD_EVAL, 24'sh7FFFFF));
      send(with_x(CMD_EVAL, -24'sh800000));
      send(with_x(CMD_EVAL, 24'sh000000));
      send(with_x(CMD_EVAL, 24'sh100000));
      send(with_x(CMD_TERMS, 24'sh7FFFFF));
      send(with_x(CMD_TERMS, -24'sh0C0000));
      for (int i = 0; i < 3; i++) begin
         c = make_cmd(CMD_READ); c.index = 6'(i); send(c);
      end
      c = make_cmd(CMD_READ); c.index = 6'd63; send(c);
      send(make_cmd(CMD_NONE6));
      send(make_cmd(CMD_NONE7));
      send(make_cmd(CMD_CLEAR));
      send(make_eval(CMD_TERMS));

      random_phase = 1;
      items = 0;
      terms = 0;
      while (items < 500) begin
         if (items > 440) quiet = 1;
         if ($urandom_range(0, 30) == 0) begin
            send(make_cmd(CMD_CLEAR));
            terms = 0;
            for (int i = 0; i < 66; i++) begin
               send(make_term(3'd1));
               terms++;
            end
            send(make_eval(CMD_EVAL));
            send(make_eval(CMD_TERMS));
            c = make_cmd(CMD_READ); c.index = 6'd63; send(c);
            items += 70;
         end
         send(make_cmd(CMD_CLEAR));
         terms = 0;
         items++;
         target = $urandom_range(1, 6);
         while (terms < target) begin
            send(make_term(($urandom_range(0, 3) == 0) ? 3'd7 : 3'd2));
            terms++;
            items++;
         end
         repeat ($urandom_range(2, 6)) begin
            case ($urandom_range(0, 9)) inside
               [0:3]: send(make_eval(CMD_EVAL));
               [4:6]: send(make_eval(CMD_TERMS));
               [7:8]: begin
                  c = make_cmd(CMD_READ);
                  if ($urandom_range(0, 2) != 0) c.index = 6'($urandom_range(0, terms - 1));
                  send(c);
               end
               default: send(make_cmd(3'($urandom_range(5, 7))));
            endcase
            items++;
         end
      end
      quiet = 1;
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("multivariate_poly_eval_gradient_top_tb passed");
      else
         $display("multivariate_poly_eval_gradient_top_tb failed");
      $finish;
   end

endmodule

>>> files.f
src/mpoly_pkg.sv
src/mpoly_ram.sv
src/mpoly_mul.sv
src/multivariate_poly_eval_gradient_top.sv
tb/multivariate_poly_eval_gradient_checker.sv
tb/multivariate_poly_eval_gradient_top_tb.sv
